// ===== design/trace_block_event_collator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trace block event collator
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRACE_BLOCK_EVENT_COLLATOR_ASSERT_SVH
`define TRACE_BLOCK_EVENT_COLLATOR_ASSERT_SVH

// Same-cycle implication
`define TBEC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TBEC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tbec_pkg.sv =====
// ----------------------------------------------------------------------------
// tbec_pkg
// Types, sizes and helpers shared by the trace block event collator.
// ----------------------------------------------------------------------------
package tbec_pkg;

	localparam int THREADS     = 8;
	localparam int LANE_W      = $clog2(THREADS);
	localparam int LANE_CNT_W  = $clog2(THREADS + 1);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int MAX_REGIONS = 4096;
	localparam int REG_CNT_W   = $clog2(MAX_REGIONS + 1);
	localparam int MEM_DEPTH   = THREADS * STACK_DEPTH;
	localparam int ADDR_W      = LANE_W + SP_W;
	localparam int KEY_W       = 24;
	localparam int CLK_W       = 64;
	localparam int FRAME_W     = 32;
	localparam int OFF_W       = 32;

	typedef enum logic [1:0] {
		OP_FRAME   = 2'd0,
		OP_BEGIN   = 2'd1,
		OP_END     = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_REGION = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_DROP   = 2'd2
	} kind_t;

	localparam logic [1:0] CFG_SCOPE_TOP   = 2'd0;
	localparam logic [1:0] CFG_SCOPE_UNIT  = 2'd1;
	localparam logic [1:0] CFG_SCOPE_INDEX = 2'd2;

	// Classified item handed from front to back
	typedef struct packed {
		logic               is_frame;
		logic               is_begin;
		logic               is_end;
		logic               is_restart;
		logic [31:0]        tid;
		logic [KEY_W-1:0]   key;
		logic [CLK_W-1:0]   clk;
	} item_t;

	// One open block on a lane's stack
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [CLK_W-1:0]   clk;
		logic [FRAME_W-1:0] frame;
	} entry_t;

	// Offset from frame begin, floored at zero and saturated to 32 bits
	function automatic logic [OFF_W-1:0] sat_off(input logic [CLK_W-1:0] c,
			input logic [CLK_W-1:0] f);
		logic [CLK_W:0] d;
		d = {1'b0, c} - {1'b0, f};
		if (d[CLK_W])
			return '0;
		else if (|d[CLK_W-1:OFF_W])
			return '1;
		else
			return d[OFF_W-1:0];
	endfunction

endpackage

// ===== design/tbec_front.sv =====
// ----------------------------------------------------------------------------
// tbec_front
// Accepts trace events, decodes the operation and queues them for the back.
// ----------------------------------------------------------------------------
module tbec_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [31:0]           thread_id,
	input  logic [7:0]            record_unit,
	input  logic [15:0]           record_index,
	input  logic [63:0]           clock_req,
	output logic                  q_valid,
	output tbec_pkg::item_t       q_item,
	input  logic                  q_take
);

	tbec_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	tbec_pkg::item_t dec;
	tbec_pkg::op_t   op_dec;

	// Decode the operation into one flag per class
	always_comb begin
		op_dec         = tbec_pkg::op_t'(op);
		dec.is_frame   = 1'b0;
		dec.is_begin   = 1'b0;
		dec.is_end     = 1'b0;
		dec.is_restart = 1'b0;
		unique case (op_dec)
			tbec_pkg::OP_FRAME:   dec.is_frame   = 1'b1;
			tbec_pkg::OP_BEGIN:   dec.is_begin   = 1'b1;
			tbec_pkg::OP_END:     dec.is_end     = 1'b1;
			tbec_pkg::OP_RESTART: dec.is_restart = 1'b1;
			default:              dec.is_restart = 1'b1;
		endcase
		dec.tid = thread_id;
		dec.key = {record_unit, record_index};
		dec.clk = clock_req;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_take)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_take);
		end
	end

	// Store the decoded item
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= dec;
	end

endmodule

// ===== design/tbec_back.sv =====
// ----------------------------------------------------------------------------
// tbec_back
// Executes queued items: lane lookup, stack push and pop, result assembly.
// ----------------------------------------------------------------------------
`include "trace_block_event_collator_assert.svh"

module tbec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  tbec_pkg::item_t       q_item,
	output logic                  q_take,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            kind,
	output logic [7:0]            region_unit,
	output logic [15:0]           region_index,
	output logic [2:0]            lane,
	output logic [63:0]           cycle_count,
	output logic [31:0]           start_offset,
	output logic [31:0]           end_offset,
	output logic [31:0]           frame_number
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LANE = 4'b0010,
		S_END  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                                 state_q;
	tbec_pkg::item_t                        cur_q;
	logic                                   scope_top_q;
	logic [7:0]                             scope_unit_q;
	logic [15:0]                            scope_index_q;
	logic [31:0]                            thread_ids_q [tbec_pkg::THREADS];
	logic [tbec_pkg::LANE_CNT_W-1:0]        lanes_used_q;
	logic [tbec_pkg::DEPTH_W-1:0]           depths_q [tbec_pkg::THREADS];
	logic                                   frame_open_q;
	logic [tbec_pkg::CLK_W-1:0]             fb_clk_q;
	logic [tbec_pkg::FRAME_W-1:0]           frames_q;
	logic [tbec_pkg::REG_CNT_W-1:0]         regions_q;
	logic [tbec_pkg::LANE_W-1:0]            lane_q;
	tbec_pkg::entry_t                       stack_mem [tbec_pkg::MEM_DEPTH];
	tbec_pkg::entry_t                       top_rd_s2;
	logic [tbec_pkg::KEY_W-1:0]             prev_key_s2;
	logic                                   match_q;
	logic                                   ok_q;
	logic [tbec_pkg::CLK_W-1:0]             dur_q;
	logic [tbec_pkg::OFF_W-1:0]             so_q;
	logic [tbec_pkg::OFF_W-1:0]             eo_q;
	logic                                   out_valid_q;

	logic                                   hit;
	logic [tbec_pkg::LANE_W-1:0]            hit_lane;
	logic                                   tbl_full;
	logic [tbec_pkg::LANE_W-1:0]            sel_lane;
	logic [tbec_pkg::DEPTH_W-1:0]           sel_depth;
	logic                                   lane_ok;
	logic                                   stk_full;
	logic [tbec_pkg::ADDR_W-1:0]            wr_addr;
	logic [tbec_pkg::ADDR_W-1:0]            top_addr;
	logic [tbec_pkg::ADDR_W-1:0]            prev_addr;
	logic                                   out_free;
	logic                                   lane_emit;
	logic                                   lane_stall;
	logic                                   emit_region;
	logic                                   emit_stall;
	logic                                   out_load;
	logic                                   push_wr;
	logic                                   reg_full;
	logic [tbec_pkg::DEPTH_W-1:0]           cur_depth;
	logic                                   scope_ok;
	logic                                   frame_ok;
	logic [tbec_pkg::CLK_W:0]               dur_full;
	tbec_pkg::kind_t                        o_kind;
	logic [tbec_pkg::KEY_W-1:0]             o_key;
	logic [tbec_pkg::LANE_W-1:0]            o_lane;
	logic [tbec_pkg::CLK_W-1:0]             o_cyc;
	logic [tbec_pkg::OFF_W-1:0]             o_so;
	logic [tbec_pkg::OFF_W-1:0]             o_eo;

	assign cfg_ready = 1'b1;

	// Look up the thread in the lane table
	always_comb begin
		hit      = 1'b0;
		hit_lane = '0;
		for (int i = 0; i < tbec_pkg::THREADS; i++) begin
			if (!hit && (tbec_pkg::LANE_CNT_W'(i) < lanes_used_q) &&
					(thread_ids_q[i] == cur_q.tid)) begin
				hit      = 1'b1;
				hit_lane = tbec_pkg::LANE_W'(i);
			end
		end
		tbl_full  = (lanes_used_q >= tbec_pkg::LANE_CNT_W'(tbec_pkg::THREADS));
		sel_lane  = hit ? hit_lane : lanes_used_q[tbec_pkg::LANE_W-1:0];
		sel_depth = hit ? depths_q[hit_lane] : '0;
		lane_ok   = hit || !tbl_full;
		stk_full  = (sel_depth >= tbec_pkg::DEPTH_W'(tbec_pkg::STACK_DEPTH));
		wr_addr   = {sel_lane, sel_depth[tbec_pkg::SP_W-1:0]};
		top_addr  = {sel_lane, sel_depth[tbec_pkg::SP_W-1:0] - tbec_pkg::SP_W'(1)};
		prev_addr = {sel_lane, sel_depth[tbec_pkg::SP_W-1:0] - tbec_pkg::SP_W'(2)};
	end

	// Decide emission and stalls
	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		lane_emit   = frame_open_q && (cur_q.is_frame ||
			((cur_q.is_begin || cur_q.is_end) && !lane_ok) ||
			(cur_q.is_begin && lane_ok && stk_full));
		lane_stall  = (state_q == S_LANE) && lane_emit && !out_free;
		emit_region = (state_q == S_EMIT) && match_q && ok_q;
		emit_stall  = emit_region && !out_free;
		out_load    = ((state_q == S_LANE) && lane_emit || emit_region) && out_free;
		push_wr     = (state_q == S_LANE) && frame_open_q && cur_q.is_begin &&
			lane_ok && !stk_full;
		reg_full    = (regions_q >= tbec_pkg::REG_CNT_W'(tbec_pkg::MAX_REGIONS));
		q_take      = (state_q == S_IDLE) && q_valid;
	end

	// Assemble the result fields
	always_comb begin
		o_kind = tbec_pkg::KIND_DROP;
		o_key  = '0;
		o_lane = '0;
		o_cyc  = '0;
		o_so   = '0;
		o_eo   = '0;
		if (state_q == S_EMIT) begin
			o_lane = lane_q;
			if (!reg_full) begin
				o_kind = tbec_pkg::KIND_REGION;
				o_key  = cur_q.key;
				o_cyc  = dur_q;
				o_so   = so_q;
				o_eo   = eo_q;
			end
		end else if (cur_q.is_frame) begin
			o_kind = tbec_pkg::KIND_FRAME;
			o_cyc  = cur_q.clk - fb_clk_q;
			o_eo   = tbec_pkg::sat_off(cur_q.clk, fb_clk_q);
		end else if (lane_ok) begin
			o_lane = sel_lane;
		end
	end

	// Evaluate the popped block
	always_comb begin
		cur_depth = depths_q[lane_q];
		if (cur_depth == tbec_pkg::DEPTH_W'(1))
			scope_ok = scope_top_q;
		else
			scope_ok = !scope_top_q && (prev_key_s2 == {scope_unit_q, scope_index_q});
		frame_ok = (top_rd_s2.frame == frames_q);
		dur_full = {1'b0, cur_q.clk} - {1'b0, top_rd_s2.clk};
	end

	// Sequence control and collation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scope_top_q   <= 1'b1;
			lanes_used_q  <= '0;
			frame_open_q  <= 1'b0;
			fb_clk_q      <= '0;
			frames_q      <= '0;
			regions_q     <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < tbec_pkg::THREADS; i++)
				depths_q[i] <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_valid) begin
				case (cfg_index)
					tbec_pkg::CFG_SCOPE_TOP: scope_top_q <= cfg_data[0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid)
						state_q <= S_LANE;
				end
				S_LANE: begin
					if (!lane_stall) begin
						// an end with an open block goes on to the stack read
						if (cur_q.is_end && frame_open_q && lane_ok && (sel_depth != '0))
							state_q <= S_END;
						else
							state_q <= S_IDLE;
						if (cur_q.is_restart) begin
							lanes_used_q <= '0;
							frame_open_q <= 1'b0;
							fb_clk_q     <= '0;
							frames_q     <= '0;
							regions_q    <= '0;
							for (int i = 0; i < tbec_pkg::THREADS; i++)
								depths_q[i] <= '0;
						end else if (cur_q.is_frame) begin
							if (frame_open_q)
								frames_q <= frames_q + 1'b1;
							frame_open_q <= 1'b1;
							fb_clk_q     <= cur_q.clk;
							regions_q    <= '0;
						end else if (frame_open_q && lane_ok) begin
							if (!hit)
								lanes_used_q <= lanes_used_q + 1'b1;
							if (cur_q.is_begin && !stk_full)
								depths_q[sel_lane] <= sel_depth + 1'b1;
							else if (!hit)
								depths_q[sel_lane] <= '0;
						end
					end
				end
				S_END: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!emit_stall) begin
						state_q <= S_IDLE;
						if (match_q) begin
							depths_q[lane_q] <= cur_depth - 1'b1;
							if (ok_q && !reg_full)
								regions_q <= regions_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the scope unit and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scope_unit_q  <= '0;
			scope_index_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tbec_pkg::CFG_SCOPE_UNIT:  scope_unit_q  <= cfg_data[7:0];
				tbec_pkg::CFG_SCOPE_INDEX: scope_index_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture item, lane table and evaluation results
	always_ff @(posedge clk) begin
		if (q_take)
			cur_q <= q_item;
		if ((state_q == S_LANE) && !lane_stall && !cur_q.is_restart &&
				!cur_q.is_frame && frame_open_q && lane_ok && !hit)
			thread_ids_q[sel_lane] <= cur_q.tid;
		if (state_q == S_LANE)
			lane_q <= sel_lane;
		if (state_q == S_END) begin
			match_q <= (top_rd_s2.key == cur_q.key);
			ok_q    <= frame_ok && scope_ok && !dur_full[tbec_pkg::CLK_W] &&
				(dur_full[tbec_pkg::CLK_W-1:0] != '0);
			dur_q   <= dur_full[tbec_pkg::CLK_W-1:0];
			so_q    <= tbec_pkg::sat_off(top_rd_s2.clk, fb_clk_q);
			eo_q    <= tbec_pkg::sat_off(cur_q.clk, fb_clk_q);
		end
		if (out_load) begin
			kind         <= o_kind;
			region_unit  <= o_key[23:16];
			region_index <= o_key[15:0];
			lane         <= o_lane;
			cycle_count  <= o_cyc;
			start_offset <= o_so;
			end_offset   <= o_eo;
			frame_number <= frames_q;
		end
	end

	// Stack memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (push_wr)
			stack_mem[wr_addr] <= '{key: cur_q.key, clk: cur_q.clk, frame: frames_q};
		if (state_q == S_LANE) begin
			top_rd_s2   <= stack_mem[top_addr];
			prev_key_s2 <= stack_mem[prev_addr].key;
		end
	end

	assign out_valid = out_valid_q;

	`TBEC_ASSERT_IMP(a_lanes_bound, 1'b1,
		lanes_used_q <= tbec_pkg::LANE_CNT_W'(tbec_pkg::THREADS), "lane count overflow")
	`TBEC_ASSERT_IMP(a_pop_nonempty, (state_q == S_EMIT) && match_q,
		cur_depth != '0, "pop from an empty stack")
	`TBEC_ASSERT_NXT(a_restart_clears, (state_q == S_LANE) && cur_q.is_restart,
		(lanes_used_q == '0) && !frame_open_q, "restart left collation state")

endmodule

// ===== design/trace_block_event_collator.sv =====
// ----------------------------------------------------------------------------
// trace_block_event_collator
// Collates profiling trace events into region, frame and dropped results.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       to block   in_valid / in_stall      op thread_id record_unit
//                                               record_index clock_req
//  out      from block out_valid / out_stall    kind region_unit region_index
//                                               lane cycle_count start_offset
//                                               end_offset frame_number
//  cfg      to block   cfg_valid / cfg_ready    cfg_index cfg_data
//
//  Frame, begin and restart items pass the idle and lane states of the back
//  sequencer; end items that find an open block go through lane lookup, stack
//  read, compare and offset, pop and emit, other end items as frame items do.
//  The stack memory read is registered, which sets the end item's length.
//  A two-entry queue lets the front accept while the back is busy.
//  Reset clears lanes, stack depths, frame state, scope unit and index, and sets scope top.
//  A stalled output holds the back only when it has a new result to load.
// ----------------------------------------------------------------------------
module trace_block_event_collator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] thread_id,
	input  logic [7:0]  record_unit,
	input  logic [15:0] record_index,
	input  logic [63:0] clock_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  region_unit,
	output logic [15:0] region_index,
	output logic [2:0]  lane,
	output logic [63:0] cycle_count,
	output logic [31:0] start_offset,
	output logic [31:0] end_offset,
	output logic [31:0] frame_number,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic            q_valid;
	tbec_pkg::item_t q_item;
	logic            q_take;

	// Accept and classify items
	tbec_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.thread_id    (thread_id),
		.record_unit  (record_unit),
		.record_index (record_index),
		.clock_req    (clock_req),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_take       (q_take)
	);

	// Execute items and drive results
	tbec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_take       (q_take),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.region_unit  (region_unit),
		.region_index (region_index),
		.lane         (lane),
		.cycle_count  (cycle_count),
		.start_offset (start_offset),
		.end_offset   (end_offset),
		.frame_number (frame_number)
	);

endmodule
